/* src/utf8_field_transcoder_padder_macros.svh */
// Assertion macros used by the checker of the transcoder block.
`ifndef UTF8_FIELD_TRANSCODER_PADDER_MACROS_SVH
`define UTF8_FIELD_TRANSCODER_PADDER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define UFTP_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("uftp assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define UFTP_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("uftp assertion failed");

// The expression must never be true.
`define UFTP_ASSERT_NEVER(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("uftp assertion failed");

`endif

/* src/uftp_pkg.sv */
// Types, constants and the letter lookup of the UTF-8 field transcoder.
package uftp_pkg;

   localparam int BYTE_W = 8;
   localparam int FLEN_W = 7;
   localparam int CODE_W = 4;
   localparam int SKIP_W = 2;

   localparam logic [BYTE_W-1:0] ASCII_LIM = 8'h80;
   localparam logic [BYTE_W-1:0] LEAD_MIN  = 8'hC0;
   localparam logic [BYTE_W-1:0] LEAD3_MIN = 8'hE0;
   localparam logic [BYTE_W-1:0] LEAD4_MIN = 8'hF0;
   localparam logic [BYTE_W-1:0] PAD_TEXT  = 8'h20;
   localparam logic [BYTE_W-1:0] PAD_RAW   = 8'h30;

   localparam logic [SKIP_W-1:0] SKIP_NONE = 2'd0;
   localparam logic [SKIP_W-1:0] SKIP_ONE  = 2'd1;
   localparam logic [SKIP_W-1:0] SKIP_TWO  = 2'd2;

   localparam logic [CODE_W-1:0] CODE_MISS = 4'd0;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;   // take the accepted transaction
      logic pad;    // write one pad byte into the output register
   } uftp_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic char_emit;   // the offered item produces a byte
      logic pad_after;   // the offered item is last and leaves the field short
      logic pad_end;     // the next pad byte completes the field
   } uftp_stat_type;

   // Two-byte letters and their single-byte codes; a miss returns CODE_MISS.
   function automatic logic [CODE_W-1:0] letter_code(input logic [BYTE_W-1:0] lead,
                                                     input logic [BYTE_W-1:0] trail);
      logic [CODE_W-1:0] code;
      case ({lead, trail})
         16'hC387: code = 4'd1;
         16'hC3A7: code = 4'd2;
         16'hC49E: code = 4'd3;
         16'hC49F: code = 4'd4;
         16'hC4B0: code = 4'd5;
         16'hC4B1: code = 4'd6;
         16'hC396: code = 4'd7;
         16'hC3B6: code = 4'd8;
         16'hC59E: code = 4'd9;
         16'hC59F: code = 4'd10;
         16'hC39C: code = 4'd11;
         16'hC3BC: code = 4'd12;
         default:  code = CODE_MISS;
      endcase
      return code;
   endfunction

endpackage

/* src/uftp_if.sv */
// Valid/ready channel interfaces for the input bytes and the output field.
interface uftp_req_if;
   import uftp_pkg::*;
   logic                valid;
   logic                ready;
   logic [BYTE_W-1:0]   in_byte;
   logic                carries_byte;
   logic                is_last;
   logic [FLEN_W-1:0]   field_len;
   logic                raw_mode;

   modport source (output valid, in_byte, carries_byte, is_last, field_len, raw_mode,
                   input ready);
   modport sink   (input valid, in_byte, carries_byte, is_last, field_len, raw_mode,
                   output ready);
endinterface

interface uftp_rsp_if;
   import uftp_pkg::*;
   logic                valid;
   logic                ready;
   logic [BYTE_W-1:0]   out_byte;
   logic                out_last;

   modport source (output valid, out_byte, out_last, input ready);
   modport sink   (input valid, out_byte, out_last, output ready);
endinterface

/* src/uftp_dp.sv */
// Datapath: decoder state, byte counter, pad latch and the output register.
module uftp_dp #(
   parameter int MAX_FIELD_LEN = 64
) (
   input  logic                    clock,
   input  logic                    reset,
   input  uftp_pkg::uftp_cmd_type  cmd,
   output uftp_pkg::uftp_stat_type stat,
   input  logic [7:0]              in_byte,
   input  logic                    carries_byte,
   input  logic                    is_last,
   input  logic [6:0]              field_len,
   input  logic                    raw_mode,
   output logic [7:0]              out_byte,
   output logic                    out_last
);
   import uftp_pkg::*;

   localparam int CW = $clog2(MAX_FIELD_LEN + 1);
   localparam int LW = (CW > FLEN_W) ? CW : FLEN_W;

   logic [BYTE_W-1:0] pending_lead_ff, pending_lead_in;
   logic              lead_waiting_ff, lead_waiting_in;
   logic [SKIP_W-1:0] skip_left_ff, skip_left_in;
   logic [CW-1:0]     emitted_count_ff, emitted_count_in;
   logic [CW-1:0]     len_ff, len_in;
   logic [BYTE_W-1:0] pad_ff, pad_in;
   logic [BYTE_W-1:0] out_byte_ff, out_byte_in;
   logic              out_last_ff, out_last_in;

   logic [LW-1:0]     len_wide;
   logic [LW-1:0]     len_sat;
   logic [CW-1:0]     item_len;
   logic [CODE_W-1:0] code;
   logic              cand_valid;
   logic [BYTE_W-1:0] cand_byte;
   logic [BYTE_W-1:0] dec_lead;
   logic              dec_waiting;
   logic [SKIP_W-1:0] dec_skip;
   logic              char_emit;
   logic              char_last;
   logic [CW-1:0]     count_after;
   logic              pad_after;
   logic              pad_end;

   assign len_wide = LW'(field_len);
   assign len_sat  = (len_wide > LW'(MAX_FIELD_LEN)) ? LW'(MAX_FIELD_LEN) : len_wide;
   assign item_len = CW'(len_sat);
   assign code     = letter_code(pending_lead_ff, in_byte);

   // Character decode for the offered item.
   always_comb begin
      dec_lead    = pending_lead_ff;
      dec_waiting = lead_waiting_ff;
      dec_skip    = skip_left_ff;
      cand_valid  = 1'b0;
      cand_byte   = in_byte;
      if (carries_byte) begin
         if (raw_mode) begin
            dec_waiting = 1'b0;
            dec_skip    = SKIP_NONE;
            cand_valid  = 1'b1;
         end else if (skip_left_ff != SKIP_NONE) begin
            dec_skip = skip_left_ff - SKIP_ONE;
         end else if (lead_waiting_ff) begin
            dec_waiting = 1'b0;
            if (code != CODE_MISS) begin
               cand_valid = 1'b1;
               cand_byte  = BYTE_W'(code);
            end else if (pending_lead_ff >= LEAD4_MIN) begin
               dec_skip = SKIP_TWO;
            end else if (pending_lead_ff >= LEAD3_MIN) begin
               dec_skip = SKIP_ONE;
            end else begin
               dec_skip = SKIP_NONE;
            end
         end else if (in_byte < ASCII_LIM) begin
            cand_valid = 1'b1;
         end else if ((in_byte >= LEAD_MIN) && !is_last) begin
            dec_lead    = in_byte;
            dec_waiting = 1'b1;
         end
      end
   end

   assign char_emit   = cand_valid && (emitted_count_ff < item_len);
   assign char_last   = (CW'(emitted_count_ff + 1'b1) == item_len);
   assign count_after = CW'(emitted_count_ff + CW'(char_emit));
   assign pad_after   = is_last && (count_after < item_len);
   assign pad_end     = (CW'(emitted_count_ff + 1'b1) == len_ff);

   assign stat.char_emit = char_emit;
   assign stat.pad_after = pad_after;
   assign stat.pad_end   = pad_end;

   always_comb begin
      pending_lead_in  = pending_lead_ff;
      lead_waiting_in  = lead_waiting_ff;
      skip_left_in     = skip_left_ff;
      emitted_count_in = emitted_count_ff;
      len_in           = len_ff;
      pad_in           = pad_ff;
      out_byte_in      = out_byte_ff;
      out_last_in      = out_last_ff;
      if (cmd.load) begin
         if (char_emit) begin
            out_byte_in = cand_byte;
            out_last_in = char_last;
         end
         if (is_last) begin
            // End of field: decoder state returns to zero, the counter only
            // survives while padding is still owed.
            pending_lead_in  = '0;
            lead_waiting_in  = 1'b0;
            skip_left_in     = SKIP_NONE;
            emitted_count_in = pad_after ? count_after : '0;
            len_in           = item_len;
            pad_in           = raw_mode ? PAD_RAW : PAD_TEXT;
         end else begin
            pending_lead_in  = dec_lead;
            lead_waiting_in  = dec_waiting;
            skip_left_in     = dec_skip;
            emitted_count_in = count_after;
         end
      end else if (cmd.pad) begin
         out_byte_in      = pad_ff;
         out_last_in      = pad_end;
         emitted_count_in = pad_end ? '0 : CW'(emitted_count_ff + 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_lead_ff  <= '0;
         lead_waiting_ff  <= 1'b0;
         skip_left_ff     <= SKIP_NONE;
         emitted_count_ff <= '0;
      end else begin
         pending_lead_ff  <= pending_lead_in;
         lead_waiting_ff  <= lead_waiting_in;
         skip_left_ff     <= skip_left_in;
         emitted_count_ff <= emitted_count_in;
      end
   end

   always_ff @(posedge clock) begin
      len_ff      <= len_in;
      pad_ff      <= pad_in;
      out_byte_ff <= out_byte_in;
      out_last_ff <= out_last_in;
   end

   assign out_byte = out_byte_ff;
   assign out_last = out_last_ff;

endmodule

/* src/uftp_ctrl.sv */
// Controller: input acceptance, pad sequencing and the output valid flag.
module uftp_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   input  uftp_pkg::uftp_stat_type stat,
   output uftp_pkg::uftp_cmd_type  cmd
);
   import uftp_pkg::*;

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_PAD  = 1'b1;

   logic state_ff, state_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic slot_free;
   logic emit;

   // The output register can take a new byte when empty or being drained.
   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE) && slot_free;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      emit     = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid && req_ready) begin
               cmd.load = 1'b1;
               emit     = stat.char_emit;
               if (stat.pad_after) begin
                  state_in = ST_PAD;
               end
            end
         end
         ST_PAD: begin
            if (slot_free) begin
               cmd.pad = 1'b1;
               emit    = 1'b1;
               if (stat.pad_end) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = emit || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

/* src/utf8_field_transcoder_padder.sv */
// A byte produced by an accepted input transaction is in the output register in the next cycle.
// Throughput: one input transaction per cycle while the output drains and no padding is owed; stalls hold the input.
// A last transaction that leaves the field short is followed by pad bytes, each written when
// the single output register has room, until the field is full; input is held meanwhile.
// Reset is synchronous and active high; it clears the decoder state, counter and valid.
// No clearing pass is needed after reset.
module utf8_field_transcoder_padder #(
   parameter int MAX_FIELD_LEN = 64
) (
   input logic         clock,
   input logic         reset,
   uftp_req_if.sink    req_chan,
   uftp_rsp_if.source  rsp_chan
);
   import uftp_pkg::*;

   uftp_cmd_type  cmd;
   uftp_stat_type stat;

   uftp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   uftp_dp #(
      .MAX_FIELD_LEN (MAX_FIELD_LEN)
   ) u_dp (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .stat         (stat),
      .in_byte      (req_chan.in_byte),
      .carries_byte (req_chan.carries_byte),
      .is_last      (req_chan.is_last),
      .field_len    (req_chan.field_len),
      .raw_mode     (req_chan.raw_mode),
      .out_byte     (rsp_chan.out_byte),
      .out_last     (rsp_chan.out_last)
   );

endmodule

/* src/uftp_checker.sv */
// Port-level checks of the transcoder and the bind that attaches them.
`include "utf8_field_transcoder_padder_macros.svh"

module uftp_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_out_byte,
   input logic       rsp_out_last
);

   // A stalled output transaction keeps its valid and its payload.
   `UFTP_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid)
   `UFTP_ASSERT_NEXT(a_rsp_stable, clock, reset, rsp_valid && !rsp_ready,
                     $stable(rsp_out_byte) && $stable(rsp_out_last))

   // Input is only taken when the output register has room for its byte.
   `UFTP_ASSERT_NEVER(a_no_overrun, clock, reset, req_ready && rsp_valid && !rsp_ready)

   // The output register comes out of reset empty.
   `UFTP_ASSERT_IMPL(a_reset_empty, clock, reset, $past(reset), !rsp_valid)

endmodule

bind utf8_field_transcoder_padder uftp_checker u_uftp_checker (
   .clock        (clock),
   .reset        (reset),
   .req_ready    (req_chan.ready),
   .rsp_valid    (rsp_chan.valid),
   .rsp_ready    (rsp_chan.ready),
   .rsp_out_byte (rsp_chan.out_byte),
   .rsp_out_last (rsp_chan.out_last)
);
